// ===== sv/rhs_pkg.sv =====
// Shared types and constants for the random hyperplane signature block.
// Used by rhs_ctrl, rhs_datapath and random_hyperplane_signature.
package rhs_pkg;

  // Sizing
  localparam int MAX_DIM     = 64;
  localparam int MAX_TABLES  = 8;
  localparam int MAX_BITS    = 16;
  localparam int ACC_COUNT   = MAX_TABLES * MAX_BITS;
  localparam int STORE_DEPTH = ACC_COUNT * MAX_DIM;

  localparam int TBL_W   = $clog2(MAX_TABLES);
  localparam int BIT_W   = $clog2(MAX_BITS);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ACC_W   = $clog2(ACC_COUNT);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int LEN_W   = 7;
  localparam int NT_W    = 4;
  localparam int NB_W    = 5;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int DATA_W  = 16;
  localparam int PROD_W  = 32;
  localparam int SUM_W   = 40;
  localparam int SIG_W   = 16;

  // Operation codes
  localparam logic OP_LOAD_COEF = 1'b0;
  localparam logic OP_ELEMENT   = 1'b1;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_VECTOR_LENGTH = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TABLES_IN_USE = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BITS_IN_USE   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_EMIT
  } rhs_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_coef;   // write one coefficient
    logic start_elem;  // latch element, rewind accumulator index
    logic issue;       // read one coefficient/accumulator pair
    logic step_count;  // advance or wrap the element count
    logic emit;        // load one signature into the output register
    logic clear_acc;   // drop all accumulator contents
  } rhs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic pipe_busy;
    logic vec_done;
    logic tbl_last;
    logic out_free;
  } rhs_sts_t;

endpackage

// ===== sv/random_hyperplane_signature.sv =====
// Top level of the random hyperplane signature block.
// Instantiates rhs_ctrl and rhs_datapath; depends on rhs_pkg.
//
//   channel  signals                                   direction  handshake
//   in       op, table_sel, bit_sel, elem_sel,          input      in_valid/in_ready
//            coef_value, element_value
//   out      table_index, signature, last_signature    output     out_valid/out_ready
//   cfg      cfg_index, cfg_data                       input      cfg_wr_en, no wait
//
// A coefficient load is written as it is accepted in idle. A vector element is
// accepted, then the single shared multiply-accumulate visits every (table, bit)
// accumulator and its pipe drains; in_ready stays low meanwhile. The element that
// ends a vector emits a signature per table in use, stalling while out_ready is low.
// Reset is synchronous and active low; accumulators start at zero through per-entry
// valid bits, so there is no clearing pass. The last signature may wait in the
// output register while the next item is accepted.
module random_hyperplane_signature (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [rhs_pkg::TBL_W-1:0]         in_table_sel,
  input  logic [rhs_pkg::BIT_W-1:0]         in_bit_sel,
  input  logic [rhs_pkg::DIM_W-1:0]         in_elem_sel,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rhs_pkg::TBL_W-1:0]         out_table_index,
  output logic [rhs_pkg::SIG_W-1:0]         out_signature,
  output logic                              out_last_signature,
  input  logic                              cfg_wr_en,
  input  logic [rhs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rhs_pkg::CFG_W-1:0]         cfg_data
);
  import rhs_pkg::*;

  rhs_cmd_t cmd;
  rhs_sts_t sts;

  // Sequencer
  rhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, multiply-accumulate and output register
  rhs_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_table_sel       (in_table_sel),
    .in_bit_sel         (in_bit_sel),
    .in_elem_sel        (in_elem_sel),
    .in_coef_value      (in_coef_value),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_table_index    (out_table_index),
    .out_signature      (out_signature),
    .out_last_signature (out_last_signature)
  );

endmodule

// ===== sv/rhs_ctrl.sv =====
// Sequencer for the random hyperplane signature block.
// Depends on rhs_pkg for the state, command and status types.
module rhs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  rhs_pkg::rhs_sts_t sts,
  output rhs_pkg::rhs_cmd_t cmd
);
  import rhs_pkg::*;

  rhs_state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_ELEMENT) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (sts.sweep_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = sts.vec_done ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free && sts.tbl_last) state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_coef  = in_valid && in_op == OP_LOAD_COEF;
        cmd.start_elem = in_valid && in_op == OP_ELEMENT;
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
        cmd.step_count = !sts.pipe_busy;
      end
      S_EMIT: begin
        cmd.emit      = sts.out_free;
        cmd.clear_acc = sts.out_free && sts.tbl_last;
      end
    endcase
  end

endmodule

// ===== sv/rhs_datapath.sv =====
// Datapath: coefficient store, accumulator store, multiply-accumulate pipe,
// signature assembly and output register. Depends on rhs_pkg.
module rhs_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rhs_pkg::rhs_cmd_t                 cmd,
  output rhs_pkg::rhs_sts_t                 sts,
  input  logic                              cfg_wr_en,
  input  logic [rhs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rhs_pkg::CFG_W-1:0]         cfg_data,
  input  logic [rhs_pkg::TBL_W-1:0]         in_table_sel,
  input  logic [rhs_pkg::BIT_W-1:0]         in_bit_sel,
  input  logic [rhs_pkg::DIM_W-1:0]         in_elem_sel,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rhs_pkg::TBL_W-1:0]         out_table_index,
  output logic [rhs_pkg::SIG_W-1:0]         out_signature,
  output logic                              out_last_signature
);
  import rhs_pkg::*;

  // Configuration registers
  logic [LEN_W-1:0] cfg_len_r;
  logic [NT_W-1:0]  cfg_nt_r;
  logic [NB_W-1:0]  cfg_nb_r;
  logic [LEN_W-1:0] len_eff;
  logic [NT_W-1:0]  nt_eff;
  logic [NB_W-1:0]  nb_eff;

  // Sweep control
  logic [ACC_W-1:0]  idx_r;
  logic [DIM_W-1:0]  count_r;
  logic signed [DATA_W-1:0] x_r;

  // Pipe stages
  logic                     s1_vld_r, s2_vld_r;
  logic [ACC_W-1:0]         s1_idx_r, s2_idx_r;
  logic signed [DATA_W-1:0] coef_rd_r;
  logic [SUM_W-1:0]         acc_rd_r;
  logic                     acc_rd_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         acc_hold_r;
  logic [SUM_W-1:0]         acc_sum;

  // Stores
  logic signed [DATA_W-1:0] coef_mem [STORE_DEPTH];
  logic [SUM_W-1:0]         acc_mem  [ACC_COUNT];
  logic [MAX_TABLES-1:0][MAX_BITS-1:0] acc_vld_r;
  logic [MAX_TABLES-1:0][MAX_BITS-1:0] pos_r;

  // Emit
  logic [TBL_W-1:0]  tbl_r;
  logic [SIG_W-1:0]  sig_mask;
  logic              out_valid_r;
  logic [TBL_W-1:0]  out_table_index_r;
  logic [SIG_W-1:0]  out_signature_r;
  logic              out_last_r;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_W'(MAX_DIM);
      cfg_nt_r  <= NT_W'(MAX_TABLES);
      cfg_nb_r  <= NB_W'(MAX_BITS);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VECTOR_LENGTH: cfg_len_r <= cfg_data[LEN_W-1:0];
        CFG_TABLES_IN_USE: cfg_nt_r  <= cfg_data[NT_W-1:0];
        CFG_BITS_IN_USE:   cfg_nb_r  <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate registers into range: zero acts as one
  always_comb begin
    if (cfg_len_r == '0) len_eff = LEN_W'(1);
    else if (cfg_len_r > LEN_W'(MAX_DIM)) len_eff = LEN_W'(MAX_DIM);
    else len_eff = cfg_len_r;
    if (cfg_nt_r == '0) nt_eff = NT_W'(1);
    else if (cfg_nt_r > NT_W'(MAX_TABLES)) nt_eff = NT_W'(MAX_TABLES);
    else nt_eff = cfg_nt_r;
    if (cfg_nb_r == '0) nb_eff = NB_W'(1);
    else if (cfg_nb_r > NB_W'(MAX_BITS)) nb_eff = NB_W'(MAX_BITS);
    else nb_eff = cfg_nb_r;
  end

  // Coefficient store: load port and sweep read port
  always_ff @(posedge clk) begin
    if (cmd.load_coef) begin
      coef_mem[{in_table_sel, in_bit_sel, in_elem_sel}] <= in_coef_value;
    end
    coef_rd_r <= coef_mem[{idx_r, count_r}];
  end

  // Accumulator store: write from the add stage, read at the sweep index
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_mem[s2_idx_r] <= acc_sum;
    end
    acc_rd_r <= acc_mem[idx_r];
  end

  // Sweep index, element latch and element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      if (cmd.start_elem) idx_r <= '0;
      else if (cmd.issue) idx_r <= idx_r + ACC_W'(1);
      if (cmd.step_count) begin
        count_r <= sts.vec_done ? '0 : count_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_elem) x_r <= in_element_value;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Stage payload: tag, valid flag of the entry, product
  always_ff @(posedge clk) begin
    s1_idx_r     <= idx_r;
    acc_rd_vld_r <= acc_vld_r[idx_r[ACC_W-1:BIT_W]][idx_r[BIT_W-1:0]];
    s2_idx_r     <= s1_idx_r;
    prod_r       <= x_r * coef_rd_r;
    acc_hold_r   <= acc_rd_vld_r ? acc_rd_r : '0;
  end

  assign acc_sum = acc_hold_r + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Entry valid bits and positive flags; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_acc) begin
      acc_vld_r <= '0;
      pos_r     <= '0;
    end else if (s2_vld_r) begin
      acc_vld_r[s2_idx_r[ACC_W-1:BIT_W]][s2_idx_r[BIT_W-1:0]] <= 1'b1;
      pos_r[s2_idx_r[ACC_W-1:BIT_W]][s2_idx_r[BIT_W-1:0]] <=
        (acc_sum != '0) && !acc_sum[SUM_W-1];
    end
  end

  // Keep signature bits below the bit count
  always_comb begin
    for (int b = 0; b < SIG_W; b++) begin
      sig_mask[b] = NB_W'(b) < nb_eff;
    end
  end

  // Table counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= '0;
    end else if (cmd.emit) begin
      tbl_r <= cmd.clear_acc ? '0 : tbl_r + TBL_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_table_index_r <= tbl_r;
      out_signature_r   <= pos_r[tbl_r] & sig_mask;
      out_last_r        <= sts.tbl_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_table_index    = out_table_index_r;
  assign out_signature      = out_signature_r;
  assign out_last_signature = out_last_r;

  // Status
  assign sts.sweep_last = idx_r == ACC_W'(ACC_COUNT - 1);
  assign sts.pipe_busy  = s1_vld_r || s2_vld_r;
  assign sts.vec_done   = ({1'b0, count_r} + LEN_W'(1)) >= len_eff;
  assign sts.tbl_last   = ({1'b0, tbl_r} + NT_W'(1)) == nt_eff;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("signature loaded over an untaken result");

  a_clear_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_acc |-> !(s1_vld_r || s2_vld_r))
    else $error("accumulators cleared while a sum is in flight");

  a_count_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_count |-> !(s1_vld_r || s2_vld_r || cmd.issue))
    else $error("element count advanced before the sweep drained");

  a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && sts.sweep_last) |=> (!cmd.issue && idx_r == '0))
    else $error("sweep did not stop after the last accumulator");

endmodule

// ===== test/rhs_checker.sv =====
// Signature checker for random_hyperplane_signature: follows register writes and
// input transfers, predicts each signature and compares it with the result channel.
// Depends on rhs_pkg.
`timescale 1ns / 100ps

module rhs_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_op,
  input  logic [rhs_pkg::TBL_W-1:0]         in_table_sel,
  input  logic [rhs_pkg::BIT_W-1:0]         in_bit_sel,
  input  logic [rhs_pkg::DIM_W-1:0]         in_elem_sel,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_coef_value,
  input  logic signed [rhs_pkg::DATA_W-1:0] in_element_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rhs_pkg::TBL_W-1:0]         out_table_index,
  input  logic [rhs_pkg::SIG_W-1:0]         out_signature,
  input  logic                              out_last_signature,
  input  logic                              cfg_wr_en,
  input  logic [rhs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rhs_pkg::CFG_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                pending_count
);
  import rhs_pkg::*;

  typedef struct packed {
    logic [TBL_W-1:0] tbl;
    logic [SIG_W-1:0] sig;
    logic             last;
  } signature_t;

  // Predicted state of the block
  logic signed [DATA_W-1:0] coef_store [STORE_DEPTH];
  logic [SUM_W-1:0]         dot_acc [ACC_COUNT];
  int unsigned              elem_count;
  logic [LEN_W-1:0]         len_reg;
  logic [NT_W-1:0]          nt_reg;
  logic [NB_W-1:0]          nb_reg;

  signature_t expected_sigs [$];
  signature_t want;
  int         errors = 0;

  // Registers outside their range act as the nearest legal value
  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Add one element into every dot product; close the vector when it is complete
  task automatic accumulate_element(input logic signed [DATA_W-1:0] x);
    int unsigned              len;
    int unsigned              nt;
    int unsigned              nb;
    logic signed [PROD_W-1:0] prod;
    logic [SUM_W-1:0]         acc;
    signature_t               s;
    len = clamp_reg(len_reg, MAX_DIM);
    for (int i = 0; i < ACC_COUNT; i++) begin
      prod = x * coef_store[i * MAX_DIM + elem_count];
      dot_acc[i] = dot_acc[i] + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    elem_count++;
    if (elem_count >= len) begin
      nt = clamp_reg(nt_reg, MAX_TABLES);
      nb = clamp_reg(nb_reg, MAX_BITS);
      for (int t = 0; t < nt; t++) begin
        s.tbl = TBL_W'(t);
        s.sig = '0;
        // Set a bit only for a strictly positive dot product
        for (int b = 0; b < nb; b++) begin
          acc = dot_acc[t * MAX_BITS + b];
          if (acc != '0 && !acc[SUM_W-1]) s.sig[b] = 1'b1;
        end
        s.last = (t + 1 == nt);
        expected_sigs.insert(expected_sigs.size(), s);
      end
      for (int i = 0; i < ACC_COUNT; i++) dot_acc[i] = '0;
      elem_count = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ACC_COUNT; i++) dot_acc[i] = '0;
      elem_count = 0;
      len_reg    = LEN_W'(MAX_DIM);
      nt_reg     = NT_W'(MAX_TABLES);
      nb_reg     = NB_W'(MAX_BITS);
      expected_sigs.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VECTOR_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          CFG_TABLES_IN_USE: nt_reg  = cfg_data[NT_W-1:0];
          CFG_BITS_IN_USE:   nb_reg  = cfg_data[NB_W-1:0];
          default: ;
        endcase
      end

      // Compare each result transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_sigs.size() == 0) begin
          $display("%0t ns: signature with none expected: table %0d sig %h last %0b",
                   $time, out_table_index, out_signature, out_last_signature);
          errors++;
        end else begin
          want = expected_sigs.pop_front();
          if (out_table_index !== want.tbl) begin
            $display("%0t ns: table_index expected %0d actual %0d",
                     $time, want.tbl, out_table_index);
            errors++;
          end
          if (out_signature !== want.sig) begin
            $display("%0t ns: signature of table %0d expected %h actual %h",
                     $time, want.tbl, want.sig, out_signature);
            errors++;
          end
          if (out_last_signature !== want.last) begin
            $display("%0t ns: last_signature of table %0d expected %0b actual %0b",
                     $time, want.tbl, want.last, out_last_signature);
            errors++;
          end
        end
      end

      // Apply each input transfer to the predicted state
      if (in_valid && in_ready) begin
        if (in_op == OP_LOAD_COEF)
          coef_store[(int'(in_table_sel) * MAX_BITS + int'(in_bit_sel)) * MAX_DIM
                     + int'(in_elem_sel)] = in_coef_value;
        else
          accumulate_element(in_element_value);
      end
    end
    fail_count    <= errors;
    pending_count <= expected_sigs.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the random_hyperplane_signature testbench: clock, reset, stimulus and verdict.
// Depends on rhs_pkg, the block itself and rhs_checker.
`timescale 1ns / 100ps

module tb_top;
  import rhs_pkg::*;

  localparam int LIMIT         = 200_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 20;
  // Element positions with every coefficient loaded; vector lengths stay within them
  localparam int LOADED_DIM    = 2;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_op = OP_LOAD_COEF;
  logic [TBL_W-1:0]         in_table_sel = '0;
  logic [BIT_W-1:0]         in_bit_sel = '0;
  logic [DIM_W-1:0]         in_elem_sel = '0;
  logic signed [DATA_W-1:0] in_coef_value = '0;
  logic signed [DATA_W-1:0] in_element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [TBL_W-1:0]         out_table_index;
  logic [SIG_W-1:0]         out_signature;
  logic                     out_last_signature;
  logic                     cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]        cfg_index = CFG_VECTOR_LENGTH;
  logic [CFG_W-1:0]         cfg_data = '0;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  random_hyperplane_signature dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_table_sel       (in_table_sel),
    .in_bit_sel         (in_bit_sel),
    .in_elem_sel        (in_elem_sel),
    .in_coef_value      (in_coef_value),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_table_index    (out_table_index),
    .out_signature      (out_signature),
    .out_last_signature (out_last_signature),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  rhs_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_table_sel       (in_table_sel),
    .in_bit_sel         (in_bit_sel),
    .in_elem_sel        (in_elem_sel),
    .in_coef_value      (in_coef_value),
    .in_element_value   (in_element_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_table_index    (out_table_index),
    .out_signature      (out_signature),
    .out_last_signature (out_last_signature),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  always #1 clk = ~clk;

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive out_ready: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Mostly random values, with the extremes and zero mixed in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one item after an optional random gap; return once it transfers
  task automatic send(input logic op, input logic [TBL_W-1:0] tsel,
                      input logic [BIT_W-1:0] bsel, input logic [DIM_W-1:0] esel,
                      input logic [DATA_W-1:0] coef, input logic [DATA_W-1:0] elem);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_table_sel     <= tsel;
    in_bit_sel       <= bsel;
    in_elem_sel      <= esel;
    in_coef_value    <= coef;
    in_element_value <= elem;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_element(input logic [DATA_W-1:0] x);
    send(OP_ELEMENT, TBL_W'($urandom), BIT_W'($urandom), DIM_W'($urandom),
         DATA_W'($urandom), x);
  endtask

  // Drop valid, wait for every predicted signature, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic set_config(input int len, input int nt, input int nb);
    write_reg(CFG_VECTOR_LENGTH, len);
    write_reg(CFG_TABLES_IN_USE, nt);
    write_reg(CFG_BITS_IN_USE, nb);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int n_items;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every coefficient at the element positions that vectors reach
    for (int e = 0; e < LOADED_DIM; e++)
      for (int t = 0; t < MAX_TABLES; t++)
        for (int b = 0; b < MAX_BITS; b++)
          send(OP_LOAD_COEF, TBL_W'(t), BIT_W'(b), DIM_W'(e), pick_value(),
               DATA_W'($urandom));
    settle();

    // One-element vectors: extreme elements, and loads right before use
    set_config(1, MAX_TABLES, MAX_BITS);
    send_element(16'h7FFF);
    send_element(16'h8000);
    send_element(16'h0000);
    send_element(16'hFFFF);
    send_element(16'h0001);
    send(OP_LOAD_COEF, 3'd7, 4'd15, 6'd0, 16'h7FFF, DATA_W'($urandom));
    send_element(16'h7FFF);
    send(OP_LOAD_COEF, 3'd0, 4'd0, 6'd0, 16'h8000, DATA_W'($urandom));
    send_element(16'h8000);
    settle();

    // Zero in every register acts as one
    set_config(0, 0, 0);
    send_element(pick_value());
    send_element(pick_value());
    settle();

    // Above-maximum values act as the maximum: one element ends nothing
    set_config(127, 15, 31);
    send_element(pick_value());
    settle();
    write_reg(CFG_VECTOR_LENGTH, 1);
    cfg_wr_en <= 1'b0;
    send_element(pick_value());
    settle();

    // Lower the vector length after one element of a longer vector
    set_config(LOADED_DIM, 3, 5);
    send_element(pick_value());
    settle();
    write_reg(CFG_VECTOR_LENGTH, 1);
    cfg_wr_en <= 1'b0;
    send_element(pick_value());
    send_element(pick_value());
    settle();

    // Random phases over idle patterns and register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      n_items = PHASE_ITEMS;
      case (ph)
        // Above-maximum table and bit counts over vectors of LOADED_DIM elements
        0: set_config(LOADED_DIM, 15, 31);
        1: begin
          // Hold off the receiver while one-element vectors pile up
          set_config(1, MAX_TABLES, MAX_BITS);
          hold_req <= 1'b1;
        end
        2: set_config(LOADED_DIM, 1, 1);
        default: set_config($urandom_range(0, LOADED_DIM), $urandom_range(0, 15),
                            $urandom_range(0, 31));
      endcase
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 15)
          send(OP_LOAD_COEF, TBL_W'($urandom), BIT_W'($urandom), DIM_W'($urandom),
               pick_value(), DATA_W'($urandom));
        else
          send_element(pick_value());
      end
      settle();
    end

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rhs_pkg.sv
sv/rhs_ctrl.sv
sv/rhs_datapath.sv
sv/random_hyperplane_signature.sv
test/rhs_checker.sv
test/tb_top.sv
